// ----- rtl/prr_pkg.sv -----
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types, register indexes and reset values of the plateau rate reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package prr_pkg;

  // Default width of the bad-metric, cooldown and reduction counters
  localparam int COUNTER_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAXIMIZE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMPROVE_MARGIN  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATIENCE_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REDUCE_FACTOR   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_FLOOR      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_RATE      = 3'd6;

  // Register reset values
  localparam logic        MAXIMIZE_MODE_RST   = 1'b0;
  localparam logic [30:0] IMPROVE_MARGIN_RST  = 31'd7;
  localparam logic [15:0] PATIENCE_LIMIT_RST  = 16'd10;
  localparam logic [15:0] COOLDOWN_LENGTH_RST = 16'd0;
  localparam logic [15:0] REDUCE_FACTOR_RST   = 16'd6554;
  localparam logic [31:0] RATE_FLOOR_RST      = 32'd0;
  localparam logic [31:0] START_RATE_RST      = 32'd4294967;

  // Opcode of an input item
  localparam logic OP_METRIC  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Stream widths
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 88;

  typedef struct packed {
    logic        maximize_mode;
    logic [30:0] improve_margin;
    logic [15:0] patience_limit;
    logic [15:0] cooldown_length;
    logic [15:0] reduce_factor;
    logic [31:0] rate_floor;
    logic [31:0] start_rate;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        reduction_total;
    logic signed [31:0] best_value;
    logic               cooling;
    logic               reduced;
    logic               improved;
    logic [31:0]        rate;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/plateau_rate_reducer.sv -----
// ----------------------------------------------------------------------------
// plateau_rate_reducer
// Lowers a learning rate when a monitored metric stops improving.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one item per transfer; s_tuser is the opcode
//   (metric or restart), s_tdata the signed Q16.16 metric.
//   Master stream (m_*): one result per item with the rate, status flags,
//   best metric and reduction count.
//   Config channel (cfg_*): register index and data; write only while idle.
//   Throughput: one item per cycle while m_tready is high, set by the combinational
//   state update (improvement compare, 32x16 rate multiply and counter logic).
//   Path: the input transfer enters the input register, then the result
//   register once that is free, from which it can transfer.
//   Stall: while m_tready is low the result holds; one more item is taken
//   into the input register, after which s_tready drops.
//   Reset: rst clears both registers and loads all configuration defaults;
//   the rate starts at the default start rate, no best is known.
// ----------------------------------------------------------------------------
`default_nettype none

module plateau_rate_reducer #(
  parameter int COUNTER_BITS = prr_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Slave stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [prr_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [31:0] metric_value
  input  wire logic                               s_tuser,   // [0] opcode
  // Master stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [31:0] rate, [32] improved, [33] reduced, [34] cooling,
  // [66:35] best_value, [82:67] reduction_total, [87:83] zero
  output logic [prr_pkg::OUT_DATA_BITS-1:0]       m_tdata,
  // Configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [prr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [prr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import prr_pkg::*;

  cfg_t               cfg;
  result_t            result_next;
  result_t            out_result;
  logic               out_valid;
  logic               inq_valid;
  logic               inq_opcode;
  logic signed [31:0] inq_metric;
  logic               proc_fire;

  prr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Process the held item whenever the result register is free
  assign proc_fire = inq_valid && (!out_valid || m_tready);
  assign s_tready  = !inq_valid || proc_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (s_tready) begin
      inq_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      inq_opcode <= s_tuser;
      inq_metric <= s_tdata;
    end
  end

  prr_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (proc_fire),
    .opcode       (inq_opcode),
    .metric_value (inq_metric),
    .cfg          (cfg),
    .result       (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_result.reduction_total, out_result.best_value,
                     out_result.cooling, out_result.reduced, out_result.improved,
                     out_result.rate};

  // An empty input register always takes a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !inq_valid |-> s_tready)
    else $error("input register empty but not ready");

  // A held item is never dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    inq_valid && !proc_fire |=> inq_valid && $stable(inq_metric) && $stable(inq_opcode))
    else $error("held input item lost");

  // A stalled result stays valid and unchanged
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- rtl/prr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// prr_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_cfg_regs (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [prr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [prr_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output prr_pkg::cfg_t                               cfg
);
  import prr_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Load the defaults on reset, else store the written field, masked to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.maximize_mode   <= MAXIMIZE_MODE_RST;
      cfg.improve_margin  <= IMPROVE_MARGIN_RST;
      cfg.patience_limit  <= PATIENCE_LIMIT_RST;
      cfg.cooldown_length <= COOLDOWN_LENGTH_RST;
      cfg.reduce_factor   <= REDUCE_FACTOR_RST;
      cfg.rate_floor      <= RATE_FLOOR_RST;
      cfg.start_rate      <= START_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAXIMIZE_MODE:   cfg.maximize_mode   <= cfg_data[0];
        CFG_IMPROVE_MARGIN:  cfg.improve_margin  <= cfg_data[30:0];
        CFG_PATIENCE_LIMIT:  cfg.patience_limit  <= cfg_data[15:0];
        CFG_COOLDOWN_LENGTH: cfg.cooldown_length <= cfg_data[15:0];
        CFG_REDUCE_FACTOR:   cfg.reduce_factor   <= cfg_data[15:0];
        CFG_RATE_FLOOR:      cfg.rate_floor      <= cfg_data[31:0];
        CFG_START_RATE:      cfg.start_rate      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/prr_core.sv -----
// ----------------------------------------------------------------------------
// prr_core
// Scheduler state and the per-item decision: restart, cooldown, improvement
// test, patience count and rate reduction, all settled combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_core #(
  parameter int COUNTER_BITS = prr_pkg::COUNTER_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic               opcode,
  input  wire logic signed [31:0] metric_value,
  input  wire prr_pkg::cfg_t      cfg,
  output prr_pkg::result_t        result
);
  import prr_pkg::*;

  localparam int WIDE = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};

  // State
  logic [31:0]             rate_reg;
  logic signed [31:0]      best_reg;
  logic                    best_known;
  logic [COUNTER_BITS-1:0] bad_count;
  logic [COUNTER_BITS-1:0] cooldown_left;
  logic [COUNTER_BITS-1:0] reduction_count;

  logic [31:0]             rate_next;
  logic signed [31:0]      best_next;
  logic                    best_known_next;
  logic [COUNTER_BITS-1:0] bad_next;
  logic [COUNTER_BITS-1:0] cooldown_next;
  logic [COUNTER_BITS-1:0] reduction_next;
  logic                    improved;
  logic                    reduced;
  logic                    cooling;

  logic signed [33:0]      metric_ext;
  logic signed [33:0]      best_ext;
  logic signed [33:0]      margin_ext;
  logic                    better;
  logic [COUNTER_BITS-1:0] bad_inc;
  logic                    patience_hit;
  logic [47:0]             product;
  logic [31:0]             cand;
  logic [31:0]             cand_floored;
  logic                    lowers;
  logic [WIDE-1:0]         cool_wide;
  logic [WIDE-1:0]         reduction_wide;
  logic [COUNTER_BITS-1:0] cool_load;

  // Improvement test at full precision
  assign metric_ext = {{2{metric_value[31]}}, metric_value};
  assign best_ext   = {{2{best_reg[31]}}, best_reg};
  assign margin_ext = {3'b000, cfg.improve_margin};
  assign better = !best_known ||
                  (cfg.maximize_mode ? (metric_ext > best_ext + margin_ext)
                                     : (metric_ext < best_ext - margin_ext));

  // Saturating bad count and patience check
  assign bad_inc      = (bad_count == CTR_MAX) ? bad_count : bad_count + COUNTER_BITS'(1);
  assign patience_hit = WIDE'(bad_inc) >= WIDE'(cfg.patience_limit);

  // Reduced rate candidate, floored
  assign product      = rate_reg * cfg.reduce_factor;
  assign cand         = product[47:16];
  assign cand_floored = (cand < cfg.rate_floor) ? cfg.rate_floor : cand;
  assign lowers       = cand_floored < rate_reg;

  // Cooldown load, clamped to the counter range
  assign cool_wide = WIDE'(cfg.cooldown_length);
  assign cool_load = (cool_wide > WIDE'(CTR_MAX)) ? CTR_MAX : cool_wide[COUNTER_BITS-1:0];

  // Next state for one item
  always_comb begin
    rate_next       = rate_reg;
    best_next       = best_reg;
    best_known_next = best_known;
    bad_next        = bad_count;
    cooldown_next   = cooldown_left;
    reduction_next  = reduction_count;
    improved        = 1'b0;
    reduced         = 1'b0;
    cooling         = 1'b0;
    if (opcode == OP_RESTART) begin
      rate_next       = cfg.start_rate;
      best_next       = '0;
      best_known_next = 1'b0;
      bad_next        = '0;
      cooldown_next   = '0;
    end else if (cooldown_left != '0) begin
      cooldown_next = cooldown_left - COUNTER_BITS'(1);
      cooling       = 1'b1;
    end else if (better) begin
      best_next       = metric_value;
      best_known_next = 1'b1;
      bad_next        = '0;
      improved        = 1'b1;
    end else begin
      bad_next = bad_inc;
      if (patience_hit) begin
        if (lowers) begin
          rate_next = cand_floored;
          reduced   = 1'b1;
          if (reduction_count != CTR_MAX) begin
            reduction_next = reduction_count + COUNTER_BITS'(1);
          end
        end
        bad_next      = '0;
        cooldown_next = cool_load;
      end
    end
  end

  // Result of this item
  assign reduction_wide         = WIDE'(reduction_next);
  assign result.rate            = rate_next;
  assign result.improved        = improved;
  assign result.reduced         = reduced;
  assign result.cooling         = cooling;
  assign result.best_value      = best_next;
  assign result.reduction_total = reduction_wide[15:0];

  // Advance state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg        <= START_RATE_RST;
      best_reg        <= '0;
      best_known      <= 1'b0;
      bad_count       <= '0;
      cooldown_left   <= '0;
      reduction_count <= '0;
    end else if (fire) begin
      rate_reg        <= rate_next;
      best_reg        <= best_next;
      best_known      <= best_known_next;
      bad_count       <= bad_next;
      cooldown_left   <= cooldown_next;
      reduction_count <= reduction_next;
    end
  end

  // A reduction always lowers the rate
  a_reduce_lowers: assert property (@(posedge clk) disable iff (rst)
    fire && reduced |=> rate_reg < $past(rate_reg))
    else $error("reduction did not lower the rate");

  // Restart loads the start rate and forgets the best
  a_restart_state: assert property (@(posedge clk) disable iff (rst)
    fire && (opcode == OP_RESTART) |=>
      rate_reg == $past(cfg.start_rate) && !best_known && cooldown_left == '0)
    else $error("restart did not clear scheduler state");

  // A skipped metric neither improves nor reduces
  a_cooling_excl: assert property (@(posedge clk) disable iff (rst)
    fire && cooling |-> !improved && !reduced)
    else $error("cooldown item changed best or rate");

endmodule

`default_nettype wire
